@@ hw/rtl/tic_pkg.sv @@
`timescale 1ns / 1ps
package tic_pkg;

  localparam int RAD_W    = 66;
  localparam int ROOT_W   = 34;
  localparam int REM_W    = 37;
  localparam int SQ_STEPS = 33;
  localparam int SQ_LANES = 3;
  localparam int NUM_W    = 64;
  localparam int DIV_LANES = 2;
  localparam int LEN_W    = 6;

  function automatic logic [LEN_W-1:0] bit_len(input logic [ROOT_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < ROOT_W; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/triangle_incenter_unit.sv @@
// Pipeline from request to result:
//   3 setup stages, 33 square-root steps plus rounding, 4 weight stages,
//   COORD_WIDTH + 1 divider steps, one output register.
// Throughput: one triangle per cycle; the whole pipeline holds when a result is not taken.
// Reset: rst clears all valid bits and holds s_tready low; data registers are not reset.
`timescale 1ns / 1ps
module triangle_incenter_unit import tic_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // ax, ay, bx, by, cx, cy
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // center_x, center_y, degenerate
  output logic [((2*COORD_WIDTH+8)/8)*8-1:0] m_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = CW + 1;
  localparam int SQ_W   = 2 * DW;
  localparam int WW     = (62 - CW < ROOT_W) ? 62 - CW : ROOT_W;
  localparam int PW     = WW + 2;
  localparam int QW     = CW + 1;
  localparam int PRD_W  = WW + 1 + DW;
  localparam int SUM_W  = PRD_W + 1;
  localparam int OUT_W  = ((2*CW+8)/8)*8;
  localparam int LEN_SH = 2 * (32 - CW);
  localparam int T1_W   = 2*CW + 4*DW;
  localparam int T2_W   = 2*CW + 3;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // stage 1: differences and magnitudes
  logic signed [CW-1:0] ix [3];
  logic signed [CW-1:0] iy [3];
  logic signed [DW-1:0] dd [6];
  logic [DW-1:0]        mg [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ix[i] = s_tdata[2*i*CW +: CW];
      iy[i] = s_tdata[(2*i+1)*CW +: CW];
    end
    dd[0] = DW'(ix[2]) - DW'(ix[1]);
    dd[1] = DW'(iy[2]) - DW'(iy[1]);
    dd[2] = DW'(ix[2]) - DW'(ix[0]);
    dd[3] = DW'(iy[2]) - DW'(iy[0]);
    dd[4] = DW'(ix[1]) - DW'(ix[0]);
    dd[5] = DW'(iy[1]) - DW'(iy[0]);
    for (int i = 0; i < 6; i++) begin
      mg[i] = dd[i][DW-1] ? DW'(-dd[i]) : DW'(dd[i]);
    end
  end

  logic          v1, v2, v3;
  logic [DW-1:0] r1_m [6];
  logic [T1_W-1:0] r1_t, r2_t, r3_t;
  logic [SQ_W-1:0] r2_sq [6];
  logic [RAD_W-1:0] r3_rad [SQ_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_m <= mg;
      r1_t <= {dd[3], dd[5], dd[2], dd[4], iy[0], ix[0]};
      for (int i = 0; i < 6; i++) begin
        r2_sq[i] <= r1_m[i] * r1_m[i];
      end
      r2_t <= r1_t;
      for (int i = 0; i < SQ_LANES; i++) begin
        r3_rad[i] <= RAD_W'({1'b0, r2_sq[2*i]} + {1'b0, r2_sq[2*i+1]}) << LEN_SH;
      end
      r3_t <= r2_t;
    end
  end

  logic              sq_v;
  logic [ROOT_W-1:0] sq_root [SQ_LANES];
  logic [T1_W-1:0]   sq_t;

  tic_sqrt #(.TAG_W(T1_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .rad       (r3_rad),
    .tag_in    (r3_t),
    .out_valid (sq_v),
    .root      (sq_root),
    .tag_out   (sq_t)
  );

  // stage 4: weight scale
  logic [ROOT_W-1:0] wmax;
  logic [LEN_W-1:0]  wlen;

  always_comb begin
    wmax = sq_root[0];
    if (sq_root[1] > wmax) wmax = sq_root[1];
    if (sq_root[2] > wmax) wmax = sq_root[2];
    wlen = bit_len(wmax);
  end

  logic              v4, v5, v6, v7;
  logic [ROOT_W-1:0] r4_l [SQ_LANES];
  logic [LEN_W-1:0]  r4_s;
  logic [T1_W-1:0]   r4_t, r5_t;
  logic [WW-1:0]     r5_w1, r5_w2;
  logic [PW-1:0]     r5_per, r6_per, r7_per;
  logic signed [PRD_W-1:0] r6_px1, r6_px2, r6_py1, r6_py2;
  logic [2*CW-1:0]   r6_base;
  logic [NUM_W-1:0]  r7_n [DIV_LANES];
  logic [T2_W-1:0]   r7_t;

  logic signed [DW-1:0] t_d1x, t_d2x, t_d1y, t_d2y;
  assign t_d1x = r5_t[2*CW +: DW];
  assign t_d2x = r5_t[2*CW+DW +: DW];
  assign t_d1y = r5_t[2*CW+2*DW +: DW];
  assign t_d2y = r5_t[2*CW+3*DW +: DW];

  logic signed [SUM_W-1:0] sx, sy;
  logic [SUM_W-1:0]        mx, my;

  always_comb begin
    sx = SUM_W'(r6_px1) + SUM_W'(r6_px2);
    sy = SUM_W'(r6_py1) + SUM_W'(r6_py2);
    mx = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
    my = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= sq_v;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_l   <= sq_root;
      r4_s   <= (wlen > LEN_W'(WW)) ? wlen - LEN_W'(WW) : '0;
      r4_t   <= sq_t;
      r5_w1  <= WW'(r4_l[1] >> r4_s);
      r5_w2  <= WW'(r4_l[2] >> r4_s);
      r5_per <= PW'(r4_l[0] >> r4_s) + PW'(r4_l[1] >> r4_s) + PW'(r4_l[2] >> r4_s);
      r5_t   <= r4_t;
      r6_px1 <= $signed({1'b0, r5_w1}) * t_d1x;
      r6_px2 <= $signed({1'b0, r5_w2}) * t_d2x;
      r6_py1 <= $signed({1'b0, r5_w1}) * t_d1y;
      r6_py2 <= $signed({1'b0, r5_w2}) * t_d2y;
      r6_per <= r5_per;
      r6_base <= r5_t[2*CW-1:0];
      r7_n[0] <= NUM_W'(mx) + NUM_W'(r6_per >> 1);
      r7_n[1] <= NUM_W'(my) + NUM_W'(r6_per >> 1);
      r7_per  <= r6_per;
      r7_t    <= {(r6_per == '0), sy[SUM_W-1], sx[SUM_W-1], r6_base};
    end
  end

  logic            dv_v;
  logic [QW-1:0]   dv_q [DIV_LANES];
  logic [T2_W-1:0] dv_t;

  tic_div #(.QW(QW), .PW(PW), .TAG_W(T2_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .num       (r7_n),
    .per       (r7_per),
    .tag_in    (r7_t),
    .out_valid (dv_v),
    .quo       (dv_q),
    .tag_out   (dv_t)
  );

  function automatic logic [CW-1:0] add_sat(input logic [CW-1:0] base,
                                            input logic [QW-1:0] q,
                                            input logic neg);
    logic [CW+1:0] b;
    logic [CW+1:0] qe;
    logic [CW+1:0] r;
    b  = {{2{base[CW-1]}}, base};
    qe = {1'b0, q};
    r  = neg ? b - qe : b + qe;
    if (r[CW+1:CW-1] == 3'b000 || r[CW+1:CW-1] == 3'b111) begin
      return r[CW-1:0];
    end
    return r[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  logic          ov, odeg;
  logic [CW-1:0] ocx, ocy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odeg <= dv_t[2*CW+2];
      if (dv_t[2*CW+2]) begin
        ocx <= '0;
        ocy <= '0;
      end else begin
        ocx <= add_sat(dv_t[CW-1:0], dv_q[0], dv_t[2*CW]);
        ocy <= add_sat(dv_t[2*CW-1:CW], dv_q[1], dv_t[2*CW+1]);
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = OUT_W'({odeg, ocy, ocx});

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && odeg |-> ocx == '0 && ocy == '0)
    else $error("degenerate result with nonzero center");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a waiting result");
`endif

endmodule

@@ hw/rtl/tic_sqrt.sv @@
`timescale 1ns / 1ps
module tic_sqrt import tic_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad [SQ_LANES],
  input  logic [TAG_W-1:0]  tag_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root [SQ_LANES],
  output logic [TAG_W-1:0]  tag_out
);

  logic              vld [SQ_STEPS];
  logic [TAG_W-1:0]  tag [SQ_STEPS];
  logic [RAD_W-1:0]  rd  [SQ_STEPS][SQ_LANES];
  logic [REM_W-1:0]  rm  [SQ_STEPS][SQ_LANES];
  logic [ROOT_W-2:0] rt  [SQ_STEPS][SQ_LANES];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic              p_v;
    logic [TAG_W-1:0]  p_tag;
    logic [RAD_W-1:0]  p_rd [SQ_LANES];
    logic [REM_W-1:0]  p_rm [SQ_LANES];
    logic [ROOT_W-2:0] p_rt [SQ_LANES];
    logic [REM_W-1:0]  rem_s [SQ_LANES];
    logic [REM_W-1:0]  trial [SQ_LANES];
    logic [REM_W-1:0]  n_rm [SQ_LANES];
    logic [ROOT_W-2:0] n_rt [SQ_LANES];

    if (k == 0) begin : g_first
      always_comb begin
        p_v   = in_valid;
        p_tag = tag_in;
        for (int l = 0; l < SQ_LANES; l++) begin
          p_rd[l] = rad[l];
          p_rm[l] = '0;
          p_rt[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        p_v   = vld[k-1];
        p_tag = tag[k-1];
        for (int l = 0; l < SQ_LANES; l++) begin
          p_rd[l] = rd[k-1][l];
          p_rm[l] = rm[k-1][l];
          p_rt[l] = rt[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < SQ_LANES; l++) begin
        rem_s[l] = {p_rm[l][REM_W-3:0], p_rd[l][RAD_W-1 -: 2]};
        trial[l] = REM_W'({p_rt[l], 2'b01});
        if (rem_s[l] >= trial[l]) begin
          n_rm[l] = rem_s[l] - trial[l];
          n_rt[l] = {p_rt[l][ROOT_W-3:0], 1'b1};
        end else begin
          n_rm[l] = rem_s[l];
          n_rt[l] = {p_rt[l][ROOT_W-3:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= p_tag;
        for (int l = 0; l < SQ_LANES; l++) begin
          rd[k][l] <= p_rd[l] << 2;
          rm[k][l] <= n_rm[l];
          rt[k][l] <= n_rt[l];
        end
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_out <= tag[SQ_STEPS-1];
      for (int l = 0; l < SQ_LANES; l++) begin
        if (rm[SQ_STEPS-1][l] > REM_W'(rt[SQ_STEPS-1][l])) begin
          root[l] <= ROOT_W'(rt[SQ_STEPS-1][l]) + ROOT_W'(1);
        end else begin
          root[l] <= ROOT_W'(rt[SQ_STEPS-1][l]);
        end
      end
    end
  end

endmodule

@@ hw/rtl/tic_div.sv @@
`timescale 1ns / 1ps
module tic_div import tic_pkg::*; #(
  parameter int QW    = 25,
  parameter int PW    = 36,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num [DIV_LANES],
  input  logic [PW-1:0]    per,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [QW-1:0]    quo [DIV_LANES],
  output logic [TAG_W-1:0] tag_out
);

  logic             vld [QW];
  logic [TAG_W-1:0] tag [QW];
  logic [PW-1:0]    pr  [QW];
  logic [PW-1:0]    rm  [QW][DIV_LANES];
  logic [QW-1:0]    nr  [QW][DIV_LANES];
  logic [QW-1:0]    qq  [QW][DIV_LANES];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic             p_v;
    logic [TAG_W-1:0] p_tag;
    logic [PW-1:0]    p_pr;
    logic [PW-1:0]    p_rm [DIV_LANES];
    logic [QW-1:0]    p_nr [DIV_LANES];
    logic [QW-1:0]    p_qq [DIV_LANES];
    logic [PW:0]      r2   [DIV_LANES];
    logic             ge   [DIV_LANES];
    logic [PW-1:0]    n_rm [DIV_LANES];

    if (k == 0) begin : g_first
      always_comb begin
        p_v   = in_valid;
        p_tag = tag_in;
        p_pr  = per;
        for (int l = 0; l < DIV_LANES; l++) begin
          p_rm[l] = PW'(num[l] >> QW);
          p_nr[l] = num[l][QW-1:0];
          p_qq[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        p_v   = vld[k-1];
        p_tag = tag[k-1];
        p_pr  = pr[k-1];
        for (int l = 0; l < DIV_LANES; l++) begin
          p_rm[l] = rm[k-1][l];
          p_nr[l] = nr[k-1][l];
          p_qq[l] = qq[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
        r2[l] = {p_rm[l], p_nr[l][QW-1]};
        ge[l] = r2[l] >= {1'b0, p_pr};
        n_rm[l] = ge[l] ? PW'(r2[l] - {1'b0, p_pr}) : PW'(r2[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= p_tag;
        pr[k]  <= p_pr;
        for (int l = 0; l < DIV_LANES; l++) begin
          rm[k][l] <= n_rm[l];
          nr[k][l] <= p_nr[l] << 1;
          qq[k][l] <= {p_qq[l][QW-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign tag_out   = tag[QW-1];
  assign quo       = qq[QW-1];

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  localparam int CW = 24;
  localparam int IN_W = ((6*CW+7)/8)*8;
  localparam int OUT_W = ((2*CW+8)/8)*8;
  localparam int LATENCY = CW + 43;
  localparam int N_RAND = 1400;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic deg;
    logic [CW-1:0] cy, cx;
  } center_t;

  typedef struct {
    logic [CW-1:0] v[6];
    logic has_exp;
    center_t exp_val;
  } tri_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;

  triangle_incenter_unit #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  center_t centers_due[$];
  int errors = 0;
  longint cycles = 0;
  bit feeding_done = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] edge_len(input longint dx, input longint dy);
    logic [63:0] mx, my, sq, rem, root, trial, pair;
    logic [127:0] rad;
    mx = mag64(dx);
    my = mag64(dy);
    sq = mx * mx + my * my;
    rad = {64'd0, sq} << (2 * (32 - CW));
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      pair = 64'((rad >> (2 * i)) & 128'd3);
      rem = (rem << 2) | pair;
      root = root << 1;
      trial = (root << 1) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    if (rem > root) root++;
    return root;
  endfunction

  function automatic logic [CW-1:0] center_axis(input longint base, input longint d1,
      input longint d2, input logic [63:0] w1, input logic [63:0] w2, input logic [63:0] per);
    longint num, r, hi, lo;
    logic [63:0] q;
    num = longint'(w1) * d1 + longint'(w2) * d2;
    q = (mag64(num) + per / 2) / per;
    r = base + (num < 0 ? -longint'(q) : longint'(q));
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[CW-1:0];
  endfunction

  function automatic center_t incenter_of(input logic [CW-1:0] v[6]);
    longint p[6];
    logic [63:0] la, lb, lc, wmax, per;
    int s;
    center_t c;
    for (int i = 0; i < 6; i++) p[i] = longint'($signed(v[i]));
    la = edge_len(p[4] - p[2], p[5] - p[3]);
    lb = edge_len(p[4] - p[0], p[5] - p[1]);
    lc = edge_len(p[2] - p[0], p[3] - p[1]);
    wmax = la;
    if (lb > wmax) wmax = lb;
    if (lc > wmax) wmax = lc;
    s = 0;
    while ((wmax >> s) >= (64'd1 << (62 - CW))) s++;
    la = la >> s;
    lb = lb >> s;
    lc = lc >> s;
    per = la + lb + lc;
    c = '0;
    if (per == 0) begin
      c.deg = 1;
      return c;
    end
    c.cx = center_axis(p[0], p[2] - p[0], p[4] - p[0], lb, lc, per);
    c.cy = center_axis(p[1], p[3] - p[1], p[5] - p[1], lb, lc, per);
    return c;
  endfunction

  function automatic logic [CW-1:0] rnd_coord(input int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 2047)) - CW'(1024);
      2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(0, 300))
                                  : {1'b1, {(CW-1){1'b0}}} + CW'($urandom_range(0, 300));
      default: return CW'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_triangle(input logic [CW-1:0] v[6], input center_t exp_val,
      input logic has_exp);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tdata <= IN_W'({v[5], v[4], v[3], v[2], v[1], v[0]});
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    centers_due = {centers_due, (has_exp ? exp_val : incenter_of(v))};
  endtask

  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE = CW'(256);

  tri_row_t directed[$];

  task automatic add_row(input logic [CW-1:0] a0, a1, b0, b1, c0, c1,
      input logic has_exp, input center_t e);
    tri_row_t r;
    r.v[0] = a0; r.v[1] = a1; r.v[2] = b0; r.v[3] = b1; r.v[4] = c0; r.v[5] = c1;
    r.has_exp = has_exp;
    r.exp_val = e;
    directed = {directed, r};
  endtask

  initial begin
    logic [CW-1:0] v[6];
    int mode;
    center_t none, degen, at_max, at_min;
    none = '0;
    degen = '0;
    degen.deg = 1;
    at_max = '{cx: MAXV, cy: MAXV, deg: 0};
    at_min = '{cx: MINV, cy: MINV, deg: 0};
    // coincident points
    add_row(0, 0, 0, 0, 0, 0, 1, degen);
    add_row(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1, degen);
    add_row(MINV, MINV, MINV, MINV, MINV, MINV, 1, degen);
    add_row(ONE, MINV, ONE, MINV, ONE, MINV, 1, degen);
    // two points equal: center lands on them
    add_row(MAXV, MAXV, MAXV, MAXV, MINV, MINV, 1, at_max);
    add_row(MINV, MINV, MINV, MINV, MAXV, MAXV, 1, at_min);
    add_row(MINV, MAXV, MAXV, MINV, MINV, MAXV, 0, none);
    add_row(0, 0, ONE, 0, 0, ONE, 0, none);
    add_row(0, 0, ONE, ONE, CW'(2*256), CW'(2*256), 0, none);
    add_row(MINV, MINV, MAXV, MINV, MINV, MAXV, 0, none);
    add_row(MAXV, MAXV, MINV, MAXV, MAXV, MINV, 0, none);
    add_row(MINV, 0, MAXV, 0, 0, MAXV, 0, none);
    add_row(CW'(1), 0, 0, CW'(1), 0, 0, 0, none);
    add_row(CW'(-1), CW'(-1), 0, 0, CW'(1), CW'(1), 0, none);
    add_row(MAXV, MINV, MINV, MAXV, 0, 0, 0, none);
    add_row(CW'(24'h555555), CW'(24'haaaaaa), CW'(24'h123456), CW'(24'hfedcba),
            CW'(24'h0f0f0f), CW'(24'hf0f0f0), 0, none);

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_triangle(directed[i].v, directed[i].exp_val,
                                        directed[i].has_exp);
    for (int n = 0; n < N_RAND; n++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 6; k++) v[k] = rnd_coord(mode < 4 ? 0 : mode < 7 ? 1 : mode < 9 ? 3 : 2);
      if ($urandom_range(0, 19) == 0) begin
        v[2] = v[0]; v[3] = v[1]; v[4] = v[0]; v[5] = v[1];
      end else if ($urandom_range(0, 14) == 0) begin
        v[2] = v[0]; v[3] = v[1];
      end
      send_triangle(v, none, 0);
    end
    s_tvalid <= 0;
    feeding_done = 1;
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else if (m_tready && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    center_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = center_t'(m_tdata[2*CW:0]);
      if (centers_due.size() == 0) begin
        report("unexpected request result", 64'(got), 64'd0);
      end else begin
        want = centers_due.pop_front();
        if (got.cx !== want.cx) report("center_x", 64'(got.cx), 64'(want.cx));
        if (got.cy !== want.cy) report("center_y", 64'(got.cy), 64'(want.cy));
        if (got.deg !== want.deg) report("degenerate", 64'(got.deg), 64'(want.deg));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (feeding_done && centers_due.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && centers_due.size() == 0) begin
          $display("== PASS ==");
        end else begin
          $display("== FAIL ==");
        end
        $finish;
      end
    end
  end
endmodule
